// ----- hdl/lgs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the toroidal life generation engine.
// No dependencies; every other file of the block imports this package.
package lgs_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int ROW_AW   = 5;
    localparam int STEP_CW  = 6;

    localparam logic       MODE_LOAD   = 1'b0;
    localparam logic       MODE_STEP   = 1'b1;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT  = 4'd2;

    typedef struct packed {
        logic                mode;
        logic [ROW_AW-1:0]   row_index;
        logic [MAX_COLS-1:0] row_cells;
    } item_t;

    typedef struct packed {
        logic [ROW_AW-1:0]   row_index_res;
        logic [MAX_COLS-1:0] row_cells_res;
        logic [31:0]         generation;
        logic                last_row;
    } result_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic              load_wr;
        logic              gen_inc;
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
        logic              shift;
        logic              save_row0;
        logic              compute;
        logic              use_row0;
        logic [ROW_AW-1:0] wr_row;
    } cmd_t;

endpackage

// ----- hdl/lgs_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the life engine: accepts items and walks the rows of a step.
// Depends on lgs_pkg.
module lgs_ctrl
    import lgs_pkg::*;
#(
    parameter int GRID_SIZE = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  item_t item,
    output logic  busy,
    output cmd_t  cmd
);

    localparam int EDGE = (GRID_SIZE > MAX_COLS) ? MAX_COLS : GRID_SIZE;
    localparam logic [ROW_AW:0]    EDGE_W   = (ROW_AW + 1)'(EDGE);
    localparam logic [ROW_AW-1:0]  LAST_ROW = ROW_AW'(EDGE - 1);
    localparam logic [STEP_CW-1:0] K_RD_END = STEP_CW'(EDGE);
    localparam logic [STEP_CW-1:0] K_SH_END = STEP_CW'(EDGE + 1);
    localparam logic [STEP_CW-1:0] K_END    = STEP_CW'(EDGE + 2);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_CW-1:0]  k_reg, k_next;
    logic [STEP_CW-1:0]  k_minus1, k_minus3;
    logic                accept;

    assign busy     = (state_reg == ST_STEP);
    assign accept   = start && !busy;
    assign k_minus1 = k_reg - STEP_CW'(1);
    assign k_minus3 = k_reg - STEP_CW'(3);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.mode == MODE_STEP)
                begin
                    state_next = ST_STEP;
                    k_next     = '0;
                end
            end
            ST_STEP:
            begin
                if (k_reg == K_END)
                    state_next = ST_IDLE;
                else
                    k_next = k_reg + STEP_CW'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reads go out at counts 0..EDGE, their data arrives in the cycle after, and a
    // new row is formed once the row below it is available.
    always_comb
    begin
        cmd.load_wr   = accept && (item.mode == MODE_LOAD)
                        && ({1'b0, item.row_index} < EDGE_W);
        cmd.gen_inc   = accept && (item.mode == MODE_STEP);
        cmd.rd_en     = busy && (k_reg <= K_RD_END);
        cmd.rd_addr   = (k_reg == '0) ? LAST_ROW : k_minus1[ROW_AW-1:0];
        cmd.shift     = busy && (k_reg >= STEP_CW'(1)) && (k_reg <= K_SH_END);
        cmd.save_row0 = busy && (k_reg == STEP_CW'(2));
        cmd.compute   = busy && (k_reg >= STEP_CW'(3));
        cmd.use_row0  = (k_reg == K_END);
        cmd.wr_row    = k_minus3[ROW_AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ----- hdl/lgs_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the life engine: row memory, three-row window, cell rule lanes,
// generation counter and result register. Depends on lgs_pkg.
module lgs_datapath
    import lgs_pkg::*;
#(
    parameter int GRID_SIZE = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  cmd_t    cmd,
    output result_t result,
    output logic    result_valid
);

    localparam int EDGE = (GRID_SIZE > MAX_COLS) ? MAX_COLS : GRID_SIZE;
    localparam logic [MAX_COLS-1:0] ROW_MASK =
        (EDGE >= MAX_COLS) ? '1 : MAX_COLS'((64'd1 << EDGE) - 64'd1);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(EDGE - 1);

    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [MAX_COLS-1:0] up_reg, mid_reg, row0_reg;
    logic [31:0]         gen_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    logic [MAX_COLS-1:0] rd_row, dn_row, new_row, wr_data;
    logic [ROW_AW-1:0]   wr_addr;
    logic                wr_en;

    // A row that was never written reads as dead cells.
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;
    assign dn_row = cmd.use_row0 ? row0_reg : rd_row;

    always_comb
    begin
        logic [3:0] sum;
        int         lf;
        int         rt;
        new_row = '0;
        for (int c = 0; c < EDGE; c++)
        begin
            lf  = (c == 0) ? EDGE - 1 : c - 1;
            rt  = (c == EDGE - 1) ? 0 : c + 1;
            sum = 4'(up_reg[lf]) + 4'(up_reg[c]) + 4'(up_reg[rt])
                + 4'(mid_reg[lf]) + 4'(mid_reg[rt])
                + 4'(dn_row[lf]) + 4'(dn_row[c]) + 4'(dn_row[rt]);
            new_row[c] = (sum == BIRTH_COUNT) || ((sum == KEEP_COUNT) && mid_reg[c]);
        end
    end

    assign wr_en   = cmd.load_wr || cmd.compute;
    assign wr_addr = cmd.compute ? cmd.wr_row : item.row_index;
    assign wr_data = cmd.compute ? new_row : (item.row_cells & ROW_MASK);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= grid_mem[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            if (cmd.rd_en)
                rd_valid_reg <= row_valid_reg[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= rd_row;
        end
        if (cmd.save_row0)
            row0_reg <= rd_row;
        if (cmd.compute)
        begin
            result_reg.row_index_res <= cmd.wr_row;
            result_reg.row_cells_res <= new_row;
            result_reg.generation    <= gen_reg;
            result_reg.last_row      <= (cmd.wr_row == LAST_ROW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.gen_inc)
                gen_reg <= gen_reg + 32'd1;
            result_valid_reg <= cmd.compute;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ----- hdl/life_generation_step.sv -----
`timescale 1ns / 1ps
// Top level of the toroidal life generation engine.
// Depends on lgs_pkg, lgs_ctrl and lgs_datapath.
//
//  channel  ports                      transfer takes place when
//  -------  -------------------------  ------------------------------------
//  item     start, busy, item          rising edge with start high, busy low
//  result   result_valid, result       rising edge ending a result_valid cycle
//
// A load transfer writes one row in the cycle it is accepted; busy stays low
// and the next item can follow at once. A step transfer raises busy while the
// grid of EDGE rows is stepped, where EDGE is GRID_SIZE capped at 32: the
// row memory has one read port, so the rows stream through a three-row
// window one per cycle, after a lead-in that fetches the wrapping top
// neighbour and the first two rows.
// Results leave back to back, one row per cycle, the first once the lead-in
// is over and its new row is registered; busy falls as the last row is shown.
// Reset clears the grid to all dead cells and the generation count to zero.
// The receiver cannot stall the result stream, so nothing is held back.
module life_generation_step
    import lgs_pkg::*;
#(
    parameter int GRID_SIZE = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output result_t result,
    output logic    result_valid
);

    cmd_t cmd;

    // The sequencer owns the row counter and decides what the datapath
    // does each cycle.
    lgs_ctrl #(
        .GRID_SIZE (GRID_SIZE)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .cmd   (cmd)
    );

    // The datapath holds the grid, forms each new row and registers it.
    lgs_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid)
    );

    // A step transfer always leads to the sequencer being busy.
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == MODE_STEP) |=> busy)
        else $error("step transfer did not start the sequencer");

    // Rows of one generation come without gaps until the last one.
    a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_row) |=> result_valid)
        else $error("gap in the result row stream");

    // The sequencer is free again once the last row is shown.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_row) |-> !busy)
        else $error("sequencer still busy on the last row");

    // A new step never begins while rows of the previous one are pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !result_valid)
        else $error("step began with rows still being emitted");

endmodule
